/* hdl/assert_macros.svh */
// Assertion macros shared by the entity mask table RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/emte_pkg.sv */
// Package for the entity mask table engine: field widths, bus layout and codes.
// No dependencies.
package emte_pkg;

    localparam int MAX_ENTITIES_DEF   = 64;
    localparam int NUM_COMPONENTS_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 6;
    localparam int CID_W    = 5;
    localparam int QM_W     = 32;
    localparam int STATUS_W = 2;

    localparam int EID_LSB   = 0;
    localparam int CID_LSB   = EID_LSB + ID_W;
    localparam int QM_LSB    = CID_LSB + CID_W;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_HAS    = 3'd3,
        CMD_KILL   = 3'd4,
        CMD_QUERY  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_DEAD    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN
    } state_t;

endpackage

/* hdl/emte_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module emte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/entity_mask_table_engine_core.sv */
// Entity mask table engine: alive bits, component masks in RAM, free-id stack in RAM.
// Depends on emte_pkg, emte_ram and assert_macros.svh.
//
// Commands arrive as transactions on the s_ group: s_tuser holds the command code and
// s_tdata the entity id, component id and query mask. Results leave as transactions on
// the m_ group: m_tdata holds the result id and has bit, m_tuser the status, and m_tlast
// marks the final result of a command.
// One command is in work at a time. Create, add, remove, has and kill read the mask
// and stack RAMs at acceptance and load their single result into the output register
// in the execute state once that register is free, when s_tready also returns; no new
// command is taken before then. A query reads one mask entry per cycle from the mask
// RAM, unless a stalled receiver holds it, for every id below the high-water mark;
// its final result and s_tready return together.
// A match is held back one step so that m_tlast can be set on the final one; a query
// with no match gives one result with the no-match status.
// The output register frees the input side: a new command is accepted while a result
// still waits. When the receiver stalls, the engine holds its work until the output
// register is free. Reset clears all alive bits, the free count and the high-water
// mark at once; the RAMs need no clearing.
`include "assert_macros.svh"

module entity_mask_table_engine_core #(
    parameter int MAX_ENTITIES   = emte_pkg::MAX_ENTITIES_DEF,
    parameter int NUM_COMPONENTS = emte_pkg::NUM_COMPONENTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // target id [5:0], component bit [10:6], query mask [42:11], zero fill
    input  logic [emte_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd [2:0]
    input  logic [emte_pkg::CMD_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_id [5:0], has_bit [6], zero fill
    output logic [emte_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [emte_pkg::STATUS_W-1:0]  m_tuser,
    output logic                           m_tlast
);

    import emte_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTITIES);
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
    localparam logic [ID_W:0]    MAX_ID  = (ID_W + 1)'(MAX_ENTITIES);
    localparam logic [CID_W:0]   MAX_CID = (CID_W + 1)'(NUM_COMPONENTS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic [ID_W-1:0]           eid_reg, eid_next;
    logic [CID_W-1:0]          cid_reg, cid_next;
    logic [QM_W-1:0]           qm_reg, qm_next;
    logic [MAX_ENTITIES-1:0]   alive_reg, alive_next;
    logic [CNT_W-1:0]          free_count_reg, free_count_next;
    logic [CNT_W-1:0]          high_water_reg, high_water_next;
    logic [CNT_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                      ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]          ev_idx_reg, ev_idx_next;
    logic                      hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0]          hold_id_reg, hold_id_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [ID_W-1:0]           out_id_reg, out_id_next;
    logic                      out_hb_reg, out_hb_next;
    status_t                   out_st_reg, out_st_next;
    logic                      out_last_reg, out_last_next;

    logic                      mask_we, mask_re;
    logic [IDX_W-1:0]          mask_waddr, mask_raddr;
    logic [NUM_COMPONENTS-1:0] mask_wdata, mask_rdata;
    logic                      stk_we, stk_re;
    logic [IDX_W-1:0]          stk_waddr, stk_raddr;
    logic [IDX_W-1:0]          stk_wdata, stk_rdata;

    logic                      out_free;
    logic                      accept;
    logic [CNT_W-1:0]          fc_dec;
    logic                      eok, cok;
    logic [IDX_W-1:0]          eidx;
    logic [NUM_COMPONENTS-1:0] comp_bit;
    logic [QM_W-1:0]           mask_ext;
    logic                      match, more, blocked;
    logic [IDX_W-1:0]          new_id;
    logic                      full;

    emte_ram #(
        .WIDTH (NUM_COMPONENTS),
        .DEPTH (MAX_ENTITIES)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (mask_re),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    emte_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTITIES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign fc_dec   = free_count_reg - CNT_W'(1);
    assign eok      = {1'b0, eid_reg} < MAX_ID;
    assign cok      = {1'b0, cid_reg} < MAX_CID;
    assign eidx     = eid_reg[IDX_W-1:0];
    assign comp_bit = NUM_COMPONENTS'(1) << cid_reg;
    assign mask_ext = QM_W'(mask_rdata);
    assign match    = ev_valid_reg && alive_reg[ev_idx_reg] && ((mask_ext & qm_reg) == qm_reg);
    assign more     = rd_idx_reg < high_water_reg;
    assign blocked  = match && hold_valid_reg && !out_free;
    assign full     = (free_count_reg == '0) && (high_water_reg == MAX_CNT);
    assign new_id   = (free_count_reg != '0) ? stk_rdata : high_water_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_QUERY)
                begin
                    state_next = S_SCAN;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!ev_valid_reg && !more)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready        = (state_reg == S_IDLE);
        cmd_next        = cmd_reg;
        eid_next        = eid_reg;
        cid_next        = cid_reg;
        qm_next         = qm_reg;
        alive_next      = alive_reg;
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        rd_idx_next     = rd_idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        out_id_next     = out_id_reg;
        out_hb_next     = out_hb_reg;
        out_st_next     = out_st_reg;
        out_last_next   = out_last_reg;
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;
        mask_we         = 1'b0;
        mask_waddr      = eidx;
        mask_wdata      = '0;
        mask_re         = 1'b0;
        mask_raddr      = s_tdata[EID_LSB +: IDX_W];
        stk_we          = 1'b0;
        stk_waddr       = free_count_reg[IDX_W-1:0];
        stk_wdata       = eidx;
        stk_re          = 1'b0;
        stk_raddr       = fc_dec[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd_t'(s_tuser);
                    eid_next = s_tdata[EID_LSB +: ID_W];
                    cid_next = s_tdata[CID_LSB +: CID_W];
                    qm_next  = s_tdata[QM_LSB +: QM_W];
                    mask_re  = 1'b1;
                    stk_re   = 1'b1;
                end
            end
            S_EXEC:
            begin
                rd_idx_next     = '0;
                ev_valid_next   = 1'b0;
                hold_valid_next = 1'b0;
                if (cmd_reg != CMD_QUERY && out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_id_next   = eid_reg;
                    out_hb_next   = 1'b0;
                    out_st_next   = ST_OK;
                    out_last_next = 1'b1;
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (full)
                            begin
                                out_st_next = ST_FULL;
                            end
                            else
                            begin
                                if (free_count_reg != '0)
                                begin
                                    free_count_next = fc_dec;
                                end
                                else
                                begin
                                    high_water_next = high_water_reg + CNT_W'(1);
                                end
                                mask_we            = 1'b1;
                                mask_waddr         = new_id;
                                mask_wdata         = '0;
                                alive_next[new_id] = 1'b1;
                                out_id_next        = ID_W'(new_id);
                            end
                        end
                        CMD_ADD:
                        begin
                            mask_we    = eok && cok;
                            mask_wdata = mask_rdata | comp_bit;
                        end
                        CMD_REMOVE:
                        begin
                            mask_we    = eok && cok;
                            mask_wdata = mask_rdata & ~comp_bit;
                        end
                        CMD_HAS:
                        begin
                            out_hb_next = eok && cok && |(mask_rdata & comp_bit);
                        end
                        CMD_KILL:
                        begin
                            if (eok && alive_reg[eidx])
                            begin
                                alive_next[eidx] = 1'b0;
                                mask_we          = 1'b1;
                                mask_wdata       = '0;
                                if (free_count_reg < MAX_CNT)
                                begin
                                    stk_we          = 1'b1;
                                    free_count_next = free_count_reg + CNT_W'(1);
                                end
                            end
                            else
                            begin
                                out_st_next = ST_DEAD;
                            end
                        end
                        default:
                        begin
                            out_st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mask_raddr = rd_idx_reg[IDX_W-1:0];
                if (!blocked)
                begin
                    if (match)
                    begin
                        if (hold_valid_reg)
                        begin
                            m_tvalid_next = 1'b1;
                            out_id_next   = ID_W'(hold_id_reg);
                            out_hb_next   = 1'b0;
                            out_st_next   = ST_OK;
                            out_last_next = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_id_next    = ev_idx_reg;
                    end
                    if (more)
                    begin
                        mask_re       = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_hb_next   = 1'b0;
                    out_last_next = 1'b1;
                    if (hold_valid_reg)
                    begin
                        out_id_next = ID_W'(hold_id_reg);
                        out_st_next = ST_OK;
                    end
                    else
                    begin
                        out_id_next = '0;
                        out_st_next = ST_NOMATCH;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            alive_reg      <= '0;
            free_count_reg <= '0;
            high_water_reg <= '0;
            ev_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            alive_reg      <= alive_next;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            ev_valid_reg   <= ev_valid_next;
            hold_valid_reg <= hold_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        eid_reg      <= eid_next;
        cid_reg      <= cid_next;
        qm_reg       <= qm_next;
        rd_idx_reg   <= rd_idx_next;
        ev_idx_reg   <= ev_idx_next;
        hold_id_reg  <= hold_id_next;
        out_id_reg   <= out_id_next;
        out_hb_reg   <= out_hb_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W - 1){1'b0}}, out_hb_reg, out_id_reg};
    assign m_tuser  = out_st_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_SAME(a_free_below_hw, 1'b1, free_count_reg <= high_water_reg)
    `ASSERT_NEXT(a_accept_to_exec, s_tvalid && s_tready, state_reg == S_EXEC)
    `ASSERT_SAME(a_nomatch_is_last, m_tvalid && (m_tuser == ST_NOMATCH), m_tlast)

endmodule
